### hw/rtl/spm_pkg.sv
// Package for the static pixel mask block.
// Holds store sizes, mode codes, register reset value and shared types.
// No dependencies.
package spm_pkg;

    localparam int PIXEL_COUNT = 65536;
    localparam int IDX_W       = 16;
    localparam int CH_W        = 8;
    localparam int THR_W       = 9;
    localparam int SUM_W       = 10;

    localparam logic [SUM_W-1:0] DARK_LIMIT      = SUM_W'(10);
    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(60);

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_CMP  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic static_flag;
        logic dark;
        logic moved;
    } t_eval;

endpackage

### hw/rtl/spm_if.sv
// Valid/ready channel interfaces for pixel words and result words.
// Depends on spm_pkg for field widths.
interface spm_in_if;
    import spm_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [IDX_W-1:0] pixel_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;

    modport source (output valid, mode, pixel_index, red, green, blue, input ready);
    modport sink   (input valid, mode, pixel_index, red, green, blue, output ready);
endinterface

interface spm_out_if;
    logic valid;
    logic ready;
    logic static_flag;
    logic dark_pixel;
    logic moved_pixel;

    modport source (output valid, static_flag, dark_pixel, moved_pixel, input ready);
    modport sink   (input valid, static_flag, dark_pixel, moved_pixel, output ready);
endinterface

### hw/rtl/static_pixel_mask_by_frame_difference.sv
// Static pixel mask top level: reference and mask RAMs, read stage, output register.
// Path: an accepted pixel word passes the RAM read stage and then the output register.
// Throughput: one pixel word per cycle while the result word is taken and no mask fill runs; the RAM
// read-modify-write loop with one-deep forwarding sets this figure.
// Reset: threshold returns to 60; a mask fill pass over all 65536 entries sets all mask bits,
// with input ready low until it ends. Depends on spm_pkg, spm_if, spm_ram, spm_eval.
module static_pixel_mask_by_frame_difference
    import spm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    spm_in_if.sink           i_pix,
    spm_out_if.source        o_res,
    input  logic             i_cfg_wr_en,
    input  logic [THR_W-1:0] i_cfg_wr_data
);
    logic [THR_W-1:0] r_thr;
    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_addr;

    logic             r_s1_valid;
    logic [1:0]       r_s1_mode;
    logic [IDX_W-1:0] r_s1_idx;
    t_rgb             r_s1_pix;
    logic             r_fwd_mask_hit;
    logic             r_fwd_mask;
    logic             r_fwd_ref_hit;
    t_rgb             r_fwd_ref;

    logic             r_out_valid;
    t_eval            r_out;

    logic             in_fire;
    logic             s1_adv;
    logic             s1_wr_mask;
    logic             s1_wr_ref;
    logic             mask_rd;
    t_rgb             ref_rd;
    logic             mask_old;
    t_rgb             ref_old;
    t_eval            eval;
    t_rgb             in_rgb;

    logic             mask_we;
    logic [IDX_W-1:0] mask_waddr;
    logic             mask_wdata;

    assign in_rgb  = '{red: i_pix.red, green: i_pix.green, blue: i_pix.blue};
    assign s1_adv  = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_clearing && (!r_s1_valid || s1_adv);
    assign in_fire = i_pix.valid && i_pix.ready;

    assign s1_wr_mask = r_s1_valid && (r_s1_mode inside {MODE_LOAD, MODE_CMP});
    assign s1_wr_ref  = r_s1_valid && (r_s1_mode == MODE_LOAD);

    assign mask_old = r_fwd_mask_hit ? r_fwd_mask : mask_rd;
    assign ref_old  = r_fwd_ref_hit  ? r_fwd_ref  : ref_rd;

    assign mask_we    = r_clearing || (s1_adv && s1_wr_mask);
    assign mask_waddr = r_clearing ? r_clr_addr : r_s1_idx;
    assign mask_wdata = r_clearing ? 1'b1 : eval.static_flag;

    spm_ram #(.WIDTH(1), .DEPTH(PIXEL_COUNT)) u_mask_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mask_we),
        .i_wr_addr (mask_waddr),
        .i_wr_data (mask_wdata),
        .i_rd_en   (in_fire),
        .i_rd_addr (i_pix.pixel_index),
        .o_rd_data (mask_rd)
    );

    spm_ram #(.WIDTH($bits(t_rgb)), .DEPTH(PIXEL_COUNT)) u_ref_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv && s1_wr_ref),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (r_s1_pix),
        .i_rd_en   (in_fire),
        .i_rd_addr (i_pix.pixel_index),
        .o_rd_data (ref_rd)
    );

    spm_eval u_eval (
        .i_mode     (r_s1_mode),
        .i_pix      (r_s1_pix),
        .i_ref      (ref_old),
        .i_mask_old (mask_old),
        .i_thr      (r_thr),
        .o_eval     (eval)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESHOLD_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
            if (r_clr_addr == IDX_W'(PIXEL_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // forward the word being written back when the next word hits the same entry
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_mode      <= i_pix.mode;
            r_s1_idx       <= i_pix.pixel_index;
            r_s1_pix       <= in_rgb;
            r_fwd_mask_hit <= s1_wr_mask && (r_s1_idx == i_pix.pixel_index);
            r_fwd_mask     <= eval.static_flag;
            r_fwd_ref_hit  <= s1_wr_ref && (r_s1_idx == i_pix.pixel_index);
            r_fwd_ref      <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= eval;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.static_flag = r_out.static_flag;
    assign o_res.dark_pixel  = r_out.dark;
    assign o_res.moved_pixel = r_out.moved;
endmodule

### hw/rtl/spm_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module spm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### hw/rtl/spm_eval.sv
// Per-pixel dark and motion test and mask update.
// Depends on spm_pkg.
module spm_eval
    import spm_pkg::*;
(
    input  logic [1:0]       i_mode,
    input  t_rgb             i_pix,
    input  t_rgb             i_ref,
    input  logic             i_mask_old,
    input  logic [THR_W-1:0] i_thr,
    output t_eval            o_eval
);
    logic [SUM_W-1:0] sum;
    logic [CH_W-1:0]  d_r;
    logic [CH_W-1:0]  d_g;
    logic [CH_W-1:0]  d_b;
    logic             dark_raw;
    logic             moved_raw;

    assign sum = SUM_W'(i_pix.red) + SUM_W'(i_pix.green) + SUM_W'(i_pix.blue);
    assign d_r = (i_pix.red   >= i_ref.red)   ? i_pix.red   - i_ref.red
                                              : i_ref.red   - i_pix.red;
    assign d_g = (i_pix.green >= i_ref.green) ? i_pix.green - i_ref.green
                                              : i_ref.green - i_pix.green;
    assign d_b = (i_pix.blue  >= i_ref.blue)  ? i_pix.blue  - i_ref.blue
                                              : i_ref.blue  - i_pix.blue;
    assign dark_raw  = sum < DARK_LIMIT;
    assign moved_raw = (THR_W'(d_r) >= i_thr) || (THR_W'(d_g) >= i_thr)
                    || (THR_W'(d_b) >= i_thr);

    always_comb begin
        case (i_mode)
            MODE_LOAD: begin
                o_eval = '{static_flag: 1'b1, dark: 1'b0, moved: 1'b0};
            end
            MODE_CMP: begin
                o_eval.static_flag = i_mask_old & ~(dark_raw | moved_raw);
                o_eval.dark        = dark_raw;
                o_eval.moved       = moved_raw;
            end
            default: begin
                o_eval = '{static_flag: i_mask_old, dark: 1'b0, moved: 1'b0};
            end
        endcase
    end
endmodule

### hw/rtl/spm_checker.sv
// Port-level checker for the static pixel mask block, bound to the top level.
// Depends on the top level's port set only.
module spm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_static_flag,
    input logic i_dark_pixel,
    input logic i_moved_pixel
);
    a_fill_blocks_input: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) $rose(i_rst_n) |-> !i_in_ready)
        else $error("input ready during mask fill");

    a_flag_clears_mask: assert property (@(posedge i_clk)
        disable iff (!i_rst_n)
        i_out_valid && (i_dark_pixel || i_moved_pixel) |-> !i_static_flag)
        else $error("mask bit set on a dark or moved pixel");

    a_latency: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) i_in_valid && i_in_ready |-> ##2 i_out_valid)
        else $error("no result word two cycles after accept");

    a_out_hold: assert property (@(posedge i_clk)
        disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_static_flag)
            && $stable(i_dark_pixel) && $stable(i_moved_pixel))
        else $error("stalled result word changed");
endmodule

bind static_pixel_mask_by_frame_difference spm_checker u_spm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pix.valid),
    .i_in_ready    (i_pix.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_static_flag (o_res.static_flag),
    .i_dark_pixel  (o_res.dark_pixel),
    .i_moved_pixel (o_res.moved_pixel)
);
